// ===== sv/otsu_pkg.sv =====
`timescale 1ns / 1ps
package otsu_pkg;

  localparam int BINS       = 256;
  localparam int BIN_W      = 8;
  localparam int MAX_PIXELS = 65536;
  localparam int FRAC_BITS  = 16;
  // Bin count, class count, class intensity sum widths.
  localparam int CNT_W      = 17;
  localparam int TC_W       = 25;
  localparam int TS_W       = 32;
  localparam int PROD_W     = 2 * TS_W;
  localparam int NUM_W      = PROD_W + FRAC_BITS;
  localparam int SCORE_W    = 58;
  localparam int DCNT_W     = 7;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_UPD     = 11'b000_0000_0010,
    S_TOT_RD  = 11'b000_0000_0100,
    S_TOT_ACC = 11'b000_0000_1000,
    S_K_RD    = 11'b000_0001_0000,
    S_K_ACC   = 11'b000_0010_0000,
    S_K_CHK   = 11'b000_0100_0000,
    S_SQ      = 11'b000_1000_0000,
    S_DIV     = 11'b001_0000_0000,
    S_ADD     = 11'b010_0000_0000,
    S_CMP     = 11'b100_0000_0000
  } state_t;

endpackage

// ===== sv/otsu_threshold_from_histogram.sv =====
`timescale 1ns / 1ps
// Each pixel transfer occupies the block for a histogram read, then a write.
// The last pixel starts a threshold search: one pass totals the histogram, then each
// threshold with both classes non-empty takes two restoring divisions on one shared
// divider, and the result strobes once when the search is over.
// The receiver cannot stall, so a result never holds up the next transfer.
// Synchronous active-low reset clears the histogram valid bits and all control state.
module otsu_threshold_from_histogram (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_pixel,
  input  logic       in_last,
  output logic       out_valid,
  output logic [7:0] out_threshold,
  output logic       out_found
);

  otsu_pkg::state_t state_r, state_nxt;

  logic [otsu_pkg::CNT_W-1:0]   mem [otsu_pkg::BINS];
  logic [otsu_pkg::CNT_W-1:0]   rdata_r;
  logic [otsu_pkg::BINS-1:0]    valid_r;
  logic [otsu_pkg::BIN_W-1:0]   rd_addr;
  logic [otsu_pkg::BIN_W-1:0]   px_r;
  logic                         last_r;
  logic [otsu_pkg::BIN_W-1:0]   idx_r;
  logic [otsu_pkg::TC_W-1:0]    tc_r, c0_r, c1;
  logic [otsu_pkg::TS_W-1:0]    ts_r, s0_r, s1;
  logic [otsu_pkg::CNT_W-1:0]   hval;
  logic [otsu_pkg::CNT_W-1:0]   wdata;
  logic [otsu_pkg::TS_W-1:0]    kh;
  logic                         cls_r;
  logic [otsu_pkg::PROD_W-1:0]  prod_r;
  logic [otsu_pkg::TC_W-1:0]    div_r, rem_r, rem_nxt;
  logic [otsu_pkg::NUM_W-1:0]   num_r;
  logic [otsu_pkg::TC_W:0]      trial;
  logic                         ge;
  logic [otsu_pkg::DCNT_W-1:0]  dcnt_r;
  logic [otsu_pkg::SCORE_W-1:0] score_r, best_r;
  logic                         found_r;
  logic [otsu_pkg::BIN_W-1:0]   best_k_r;
  logic                         out_valid_r;
  logic [7:0]                   out_thr_r;
  logic                         out_found_r;
  logic                         last_k;
  logic                         skip;

  assign busy          = (state_r != otsu_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_threshold = out_thr_r;
  assign out_found     = out_found_r;

  // Histogram memory: one read and one write port, registered read data.
  assign rd_addr = (state_r == otsu_pkg::S_IDLE) ? in_pixel : idx_r;

  always_ff @(posedge clk) begin
    if (state_r == otsu_pkg::S_UPD) begin
      mem[px_r] <= wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  // A bin that was not written since the last clear reads as zero.
  always_comb begin
    if (state_r == otsu_pkg::S_UPD) begin
      hval = valid_r[px_r] ? rdata_r : '0;
    end else begin
      hval = valid_r[idx_r] ? rdata_r : '0;
    end
    wdata = (hval >= otsu_pkg::CNT_W'(otsu_pkg::MAX_PIXELS)) ? hval : hval + 1'b1;
    kh    = otsu_pkg::TS_W'(idx_r) * otsu_pkg::TS_W'(hval);
    c1    = tc_r - c0_r;
    s1    = ts_r - s0_r;
    skip  = (c0_r == '0) || (c1 == '0);
    last_k = (idx_r == otsu_pkg::BIN_W'(otsu_pkg::BINS - 1));
  end

  // One restoring division step per cycle in S_DIV.
  always_comb begin
    trial   = {rem_r, num_r[otsu_pkg::NUM_W-1]};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? otsu_pkg::TC_W'(trial - {1'b0, div_r}) : otsu_pkg::TC_W'(trial);
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      otsu_pkg::S_IDLE:    if (start) state_nxt = otsu_pkg::S_UPD;
      otsu_pkg::S_UPD:     state_nxt = last_r ? otsu_pkg::S_TOT_RD : otsu_pkg::S_IDLE;
      otsu_pkg::S_TOT_RD:  state_nxt = otsu_pkg::S_TOT_ACC;
      otsu_pkg::S_TOT_ACC: state_nxt = last_k ? otsu_pkg::S_K_RD : otsu_pkg::S_TOT_RD;
      otsu_pkg::S_K_RD:    state_nxt = otsu_pkg::S_K_ACC;
      otsu_pkg::S_K_ACC:   state_nxt = otsu_pkg::S_K_CHK;
      otsu_pkg::S_K_CHK: begin
        if (!skip) begin
          state_nxt = otsu_pkg::S_SQ;
        end else if (last_k) begin
          state_nxt = otsu_pkg::S_IDLE;
        end else begin
          state_nxt = otsu_pkg::S_K_RD;
        end
      end
      otsu_pkg::S_SQ:  state_nxt = otsu_pkg::S_DIV;
      otsu_pkg::S_DIV: begin
        if (dcnt_r == otsu_pkg::DCNT_W'(otsu_pkg::NUM_W - 1)) state_nxt = otsu_pkg::S_ADD;
      end
      otsu_pkg::S_ADD: state_nxt = cls_r ? otsu_pkg::S_CMP : otsu_pkg::S_SQ;
      otsu_pkg::S_CMP: state_nxt = last_k ? otsu_pkg::S_IDLE : otsu_pkg::S_K_RD;
      default:         state_nxt = otsu_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= otsu_pkg::S_IDLE;
      valid_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      // Search finished: strobe the result and clear the histogram.
      out_valid_r <= busy && state_nxt == otsu_pkg::S_IDLE && state_r != otsu_pkg::S_UPD;
      if (state_r == otsu_pkg::S_UPD) begin
        valid_r[px_r] <= 1'b1;
      end
      if (state_r == otsu_pkg::S_TOT_RD) begin
        found_r <= 1'b0;
      end
      if (state_r == otsu_pkg::S_CMP && (!found_r || score_r >= best_r)) begin
        found_r <= 1'b1;
      end
      if (busy && state_nxt == otsu_pkg::S_IDLE && state_r != otsu_pkg::S_UPD) begin
        valid_r     <= '0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      otsu_pkg::S_IDLE: begin
        px_r   <= in_pixel;
        last_r <= in_last;
        idx_r  <= '0;
        tc_r   <= '0;
        ts_r   <= '0;
      end
      otsu_pkg::S_TOT_ACC: begin
        tc_r  <= tc_r + otsu_pkg::TC_W'(hval);
        ts_r  <= ts_r + kh;
        idx_r <= idx_r + 1'b1;
        c0_r  <= '0;
        s0_r  <= '0;
      end
      otsu_pkg::S_K_ACC: begin
        c0_r <= c0_r + otsu_pkg::TC_W'(hval);
        s0_r <= s0_r + kh;
      end
      otsu_pkg::S_K_CHK: begin
        cls_r   <= 1'b0;
        score_r <= '0;
        if (skip) idx_r <= idx_r + 1'b1;
      end
      otsu_pkg::S_SQ: begin
        prod_r <= cls_r ? s1 * s1 : s0_r * s0_r;
        div_r  <= cls_r ? c1 : c0_r;
        dcnt_r <= '0;
      end
      otsu_pkg::S_DIV: begin
        if (dcnt_r == '0) begin
          rem_r <= '0;
          num_r <= {prod_r, {otsu_pkg::FRAC_BITS{1'b0}}};
        end else begin
          rem_r <= rem_nxt;
          num_r <= {num_r[otsu_pkg::NUM_W-2:0], ge};
        end
        dcnt_r <= dcnt_r + 1'b1;
      end
      otsu_pkg::S_ADD: begin
        // The last division step is folded into the accumulate.
        score_r <= score_r + otsu_pkg::SCORE_W'({num_r[otsu_pkg::NUM_W-2:0], ge});
        cls_r   <= 1'b1;
      end
      otsu_pkg::S_CMP: begin
        if (!found_r || score_r >= best_r) begin
          best_r   <= score_r;
          best_k_r <= idx_r;
        end
        idx_r <= idx_r + 1'b1;
      end
      default: begin
      end
    endcase
    if (state_r == otsu_pkg::S_TOT_RD) begin
      best_k_r <= '0;
    end
    // Result register, loaded at the end of the search.
    if (busy && state_nxt == otsu_pkg::S_IDLE && state_r != otsu_pkg::S_UPD) begin
      if (state_r == otsu_pkg::S_CMP && (!found_r || score_r >= best_r)) begin
        out_thr_r   <= idx_r;
        out_found_r <= 1'b1;
      end else begin
        out_thr_r   <= best_k_r;
        out_found_r <= found_r;
      end
    end
  end

endmodule

// ===== sv/otsu_checker.sv =====
`timescale 1ns / 1ps
module otsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [7:0] out_threshold,
  input logic       out_found
);

  // A result strobe lasts one cycle.
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  // The block is free again when it shows a result.
  a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy during result");

  // A result only follows a busy period.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without work");

  // An accepted transfer makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("transfer not taken");

  // No threshold is reported when none was found.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_threshold == 8'd0)) else $error("bad empty result");

endmodule

bind otsu_threshold_from_histogram otsu_checker u_otsu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_threshold (out_threshold),
  .out_found     (out_found)
);
